/* hw/rtl/i2csrt_pkg.sv */
package i2csrt_pkg;

    localparam int unsigned WordCount = 4;

    localparam logic [7:0] AddrMask    = 8'hF8;
    localparam logic [7:0] NackByte    = 8'hFF;
    localparam logic [7:0] AckByte     = 8'h00;
    localparam logic [7:0] PtrIdle     = 8'hFF;
    localparam logic [7:0] PtrConfig   = 8'h01;
    localparam logic [7:0] PtrLimit0   = 8'h02;
    localparam logic [7:0] PtrLimit1   = 8'h03;
    localparam logic [7:0] OwnAddrRst  = 8'h90;

    localparam logic [3:0] CountNone = 4'd0;
    localparam logic [3:0] CountAck  = 4'd1;
    localparam logic [3:0] CountByte = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RX_ADDR  = 4'd1,
        PH_CHK_ADDR = 4'd2,
        PH_RX_PTR   = 4'd3,
        PH_RX_DATA  = 4'd4,
        PH_PTR_ACK  = 4'd5,
        PH_DATA_ACK = 4'd6,
        PH_TX_HIGH  = 4'd7,
        PH_RX_MACK  = 4'd8,
        PH_CHK_MACK = 4'd9
    } phase_t;

    typedef logic [WordCount-1:0][15:0] word_arr_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  bytes_left;
        logic [7:0]  pointer;
        logic [1:0]  chip_select;
        logic [7:0]  config_store;
        logic [15:0] limit0;
        logic [15:0] limit1;
        logic        sda_enable;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  selected_chip;
        logic [15:0] limit_word_1;
        logic [15:0] limit_word_0;
        logic [7:0]  config_value;
        logic [3:0]  bit_count;
        logic        sda_output_enable;
        logic [7:0]  shift_value;
        logic        shift_load;
    } result_t;

endpackage

/* hw/rtl/i2c_slave_register_target.sv */
// Byte-level sequencer for an I2C slave shift unit.
// Input channel (s_*): one transaction per shift-unit event (start condition,
// finished byte or finished acknowledge bit), carrying the received byte and
// the four readable words. Output channel (m_*): exactly one result per event,
// giving the shift register load, SDA drive, next bit count and the stored
// write registers. Configuration channel (cfg_*): the slave address byte; it
// is always ready. It must be written only while no event is in flight;
// the block itself does not enforce this. An accepted event is captured in
// an input register that feeds the sequencer logic, which writes the result
// register and the protocol state in the same cycle, so one event per cycle
// is sustained while the receiver keeps m_tready high.
// Reset clears the protocol to idle, the pointer to 0xFF, the stored
// registers to zero and the address byte to 0x90; both pipeline registers
// come up empty. When the receiver stalls, the result register holds its
// transaction and the input register takes one more event before s_tready
// drops.
module i2c_slave_register_target (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // shift_in[7:0], slave_word_0[23:8], slave_word_1[39:24],
    // slave_word_2[55:40], slave_word_3[71:56]
    input  logic [71:0] s_tdata,
    // start_seen[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // shift_load[0], shift_value[8:1], sda_output_enable[9], bit_count[13:10],
    // config_value[21:14], limit_word_0[37:22], limit_word_1[53:38],
    // selected_chip[55:54]
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic                   in_valid_reg;
    logic [71:0]            in_data_reg;
    logic                   in_start_reg;
    logic                   out_valid_reg;
    i2csrt_pkg::result_t    out_data_reg;
    i2csrt_pkg::seq_state_t state_reg;
    i2csrt_pkg::seq_state_t state_next;
    i2csrt_pkg::result_t    result_next;
    logic [7:0]             own_addr_reg;
    logic                   advance;
    i2csrt_pkg::word_arr_t  words;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign words = in_data_reg[71:8];

    i2csrt_seq u_seq (
        .cur_state  (state_reg),
        .own_addr   (own_addr_reg),
        .start_seen (in_start_reg),
        .shift_in   (in_data_reg[7:0]),
        .words      (words),
        .nxt_state  (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            own_addr_reg  <= i2csrt_pkg::OwnAddrRst;
            state_reg     <= '{phase:        i2csrt_pkg::PH_IDLE,
                               bytes_left:   2'd0,
                               pointer:      i2csrt_pkg::PtrIdle,
                               chip_select:  2'd0,
                               config_store: 8'd0,
                               limit0:       16'd0,
                               limit1:       16'd0,
                               sda_enable:   1'b0};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                own_addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

endmodule

/* hw/rtl/i2csrt_seq.sv */
module i2csrt_seq (
    input  i2csrt_pkg::seq_state_t cur_state,
    input  logic [7:0]             own_addr,
    input  logic                   start_seen,
    input  logic [7:0]             shift_in,
    input  i2csrt_pkg::word_arr_t  words,
    output i2csrt_pkg::seq_state_t nxt_state,
    output i2csrt_pkg::result_t    result
);

    i2csrt_pkg::phase_t ph;
    logic               addr_match;
    logic [7:0]         tx_byte;
    logic               load;
    logic [7:0]         value;
    logic [3:0]         count;

    // A start condition restarts the address phase before the event is handled.
    assign ph         = start_seen ? i2csrt_pkg::PH_RX_ADDR : cur_state.phase;
    assign addr_match = (shift_in & i2csrt_pkg::AddrMask) == (own_addr & i2csrt_pkg::AddrMask);

    always_comb begin
        nxt_state       = cur_state;
        nxt_state.phase = ph;
        case (ph)
            i2csrt_pkg::PH_RX_ADDR: begin
                nxt_state.phase = i2csrt_pkg::PH_CHK_ADDR;
            end
            i2csrt_pkg::PH_CHK_ADDR: begin
                if (addr_match) begin
                    nxt_state.phase       = shift_in[0] ? i2csrt_pkg::PH_TX_HIGH
                                                        : i2csrt_pkg::PH_RX_PTR;
                    nxt_state.chip_select = shift_in[2:1];
                    nxt_state.bytes_left  = 2'd2;
                    nxt_state.sda_enable  = 1'b1;
                end else begin
                    nxt_state.phase   = i2csrt_pkg::PH_IDLE;
                    nxt_state.pointer = i2csrt_pkg::PtrIdle;
                end
            end
            i2csrt_pkg::PH_RX_PTR: begin
                nxt_state.sda_enable = 1'b0;
                nxt_state.phase      = i2csrt_pkg::PH_PTR_ACK;
            end
            i2csrt_pkg::PH_PTR_ACK: begin
                nxt_state.pointer = shift_in;
                if (shift_in == i2csrt_pkg::PtrConfig) begin
                    nxt_state.bytes_left = 2'd1;
                end
                nxt_state.phase      = i2csrt_pkg::PH_RX_DATA;
                nxt_state.sda_enable = 1'b1;
            end
            i2csrt_pkg::PH_RX_DATA: begin
                nxt_state.phase      = i2csrt_pkg::PH_DATA_ACK;
                nxt_state.sda_enable = 1'b0;
            end
            i2csrt_pkg::PH_DATA_ACK: begin
                if (cur_state.bytes_left != 2'd0) begin
                    case (cur_state.pointer)
                        i2csrt_pkg::PtrConfig: nxt_state.config_store = shift_in;
                        i2csrt_pkg::PtrLimit0: nxt_state.limit0 = {cur_state.limit0[7:0], shift_in};
                        i2csrt_pkg::PtrLimit1: nxt_state.limit1 = {cur_state.limit1[7:0], shift_in};
                        default: ;
                    endcase
                    nxt_state.bytes_left = cur_state.bytes_left - 2'd1;
                    nxt_state.phase      = i2csrt_pkg::PH_RX_DATA;
                    nxt_state.sda_enable = 1'b1;
                end else begin
                    nxt_state.sda_enable = 1'b0;
                    nxt_state.phase      = i2csrt_pkg::PH_IDLE;
                    nxt_state.bytes_left = 2'd0;
                    nxt_state.pointer    = i2csrt_pkg::PtrIdle;
                end
            end
            i2csrt_pkg::PH_TX_HIGH: begin
                nxt_state.sda_enable = 1'b1;
                nxt_state.phase      = i2csrt_pkg::PH_RX_MACK;
            end
            i2csrt_pkg::PH_RX_MACK: begin
                nxt_state.sda_enable = 1'b0;
                nxt_state.phase      = i2csrt_pkg::PH_CHK_MACK;
            end
            i2csrt_pkg::PH_CHK_MACK: begin
                if (shift_in[0]) begin
                    nxt_state.sda_enable = 1'b0;
                    nxt_state.phase      = i2csrt_pkg::PH_IDLE;
                    nxt_state.bytes_left = 2'd0;
                    nxt_state.pointer    = i2csrt_pkg::PtrIdle;
                end else begin
                    nxt_state.sda_enable = 1'b1;
                    nxt_state.phase      = i2csrt_pkg::PH_RX_MACK;
                end
            end
            default: ;
        endcase
    end

    assign tx_byte = ph == i2csrt_pkg::PH_TX_HIGH ? words[cur_state.chip_select][15:8]
                                                  : words[cur_state.chip_select][7:0];

    always_comb begin
        load  = 1'b0;
        value = i2csrt_pkg::AckByte;
        count = i2csrt_pkg::CountNone;
        case (ph)
            i2csrt_pkg::PH_RX_ADDR: begin
                count = i2csrt_pkg::CountByte;
            end
            i2csrt_pkg::PH_CHK_ADDR: begin
                if (addr_match) begin
                    load  = 1'b1;
                    count = i2csrt_pkg::CountAck;
                end
            end
            i2csrt_pkg::PH_RX_PTR: begin
                count = i2csrt_pkg::CountByte;
            end
            i2csrt_pkg::PH_PTR_ACK: begin
                load  = 1'b1;
                count = i2csrt_pkg::CountAck;
            end
            i2csrt_pkg::PH_RX_DATA: begin
                load  = 1'b1;
                count = i2csrt_pkg::CountByte;
            end
            i2csrt_pkg::PH_DATA_ACK: begin
                load = 1'b1;
                if (cur_state.bytes_left != 2'd0) begin
                    count = i2csrt_pkg::CountAck;
                end else begin
                    value = i2csrt_pkg::NackByte;
                end
            end
            i2csrt_pkg::PH_TX_HIGH: begin
                load  = 1'b1;
                value = tx_byte;
                count = i2csrt_pkg::CountByte;
            end
            i2csrt_pkg::PH_RX_MACK: begin
                count = i2csrt_pkg::CountAck;
            end
            i2csrt_pkg::PH_CHK_MACK: begin
                if (!shift_in[0]) begin
                    load  = 1'b1;
                    value = tx_byte;
                    count = i2csrt_pkg::CountByte;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result.shift_load        = load;
        result.shift_value       = value;
        result.sda_output_enable = nxt_state.sda_enable;
        result.bit_count         = count;
        result.config_value      = nxt_state.config_store;
        result.limit_word_0      = nxt_state.limit0;
        result.limit_word_1      = nxt_state.limit1;
        result.selected_chip     = nxt_state.chip_select;
    end

endmodule

/* hw/rtl/i2csrt_checker.sv */
module i2csrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // The result register comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Without a load the transmitted byte reads as zero.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("shift value set without load");

    a_bit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:10] == 4'd0 || m_tdata[13:10] == 4'd1
                      || m_tdata[13:10] == 4'd8))
        else $error("bit count out of range");

endmodule

bind i2c_slave_register_target i2csrt_checker u_i2csrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
